@@ rtl/pairwise_preference_tally_assert.svh @@
// assertion macros for the pairwise preference tally
`ifndef PAIRWISE_PREFERENCE_TALLY_ASSERT_SVH
`define PAIRWISE_PREFERENCE_TALLY_ASSERT_SVH
`ifndef SYNTHESIS
`define PPT_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define PPT_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define PPT_ASSERT_IMP(label, clk, rst_n, a, c)
`define PPT_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

@@ rtl/ppt_pkg.sv @@
// ----------------------------------------------------------------------------
// ppt_pkg
// shared types and constants of the pairwise preference tally
// ----------------------------------------------------------------------------
`default_nettype none
package ppt_pkg;
  localparam int MaxCand = 16;
  localparam int MaxLen = 16;
  localparam int CntW = 32;
  localparam int CandW = $clog2(MaxCand);
  localparam int LenW = $clog2(MaxLen);
  localparam int AddrW = 2 * CandW;
  localparam logic [CntW-1:0] CntMax = '1;

  localparam logic [1:0] REQ_ENTRY = 2'd0;
  localparam logic [1:0] REQ_READ = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_LONG = 2'd2;
  localparam logic [1:0] ST_SAT = 2'd3;

  typedef struct packed {
    logic [1:0] req;
    logic [CandW-1:0] cand;
    logic [31:0] score;
    logic [15:0] weight;
    logic ends;
    logic [CandW-1:0] row;
    logic [CandW-1:0] col;
    logic [CandW:0] n;
  } cmd_t;
endpackage
`default_nettype wire

@@ rtl/ppt_front.sv @@
// ----------------------------------------------------------------------------
// ppt_front
// input side: takes beats, latches the candidate count and queues commands
// ----------------------------------------------------------------------------
`default_nettype none
module ppt_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_we,
  input  wire [4:0]         cfg_wdata,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  wire [63:0]        in_tdata,
  input  wire [1:0]         in_tuser,
  input  wire               in_tlast,
  output logic              q_valid,
  input  wire               q_pop,
  output ppt_pkg::cmd_t     q_cmd
);
  import ppt_pkg::*;
  `include "pairwise_preference_tally_assert.svh"

  logic [4:0] cnt_r;
  logic [CandW:0] n_eff;
  cmd_t fifo_r [2];
  logic [1:0] fill_r;
  logic wp_r, rp_r;
  cmd_t c;
  logic push;

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= 5'd16;
    else if (cfg_we) cnt_r <= cfg_wdata;
  end

  always_comb begin
    if (cnt_r == 5'd0) n_eff = (CandW+1)'(1);
    else if (32'(cnt_r) > MaxCand) n_eff = (CandW+1)'(MaxCand);
    else n_eff = (CandW+1)'(cnt_r);
  end

  assign in_tready = (fill_r != 2'd2);
  assign push = in_tvalid && in_tready;

  always_comb begin
    c.req = in_tuser;
    c.cand = in_tdata[CandW-1:0];
    c.score = in_tdata[35:4];
    c.weight = in_tdata[51:36];
    c.ends = in_tlast;
    c.row = in_tdata[52+:CandW];
    c.col = in_tdata[56+:CandW];
    c.n = n_eff;
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      fill_r <= fill_r + 2'(push) - 2'(q_pop);
    end
  end

  assign q_valid = (fill_r != 2'd0);
  assign q_cmd = fifo_r[rp_r];

  `PPT_ASSERT_IMP(a_no_pop_empty, clk, rst_n, q_pop, q_valid)
  `PPT_ASSERT_IMP(a_fill_range, clk, rst_n, 1'b1, fill_r != 2'd3)
  `PPT_ASSERT_NXT(a_full_holds, clk, rst_n, fill_r == 2'd2 && !q_pop, fill_r == 2'd2)
endmodule
`default_nettype wire

@@ rtl/ppt_back.sv @@
// ----------------------------------------------------------------------------
// ppt_back
// execution side: walks the ballot buffer and matrix memory per command
// ----------------------------------------------------------------------------
`default_nettype none
module ppt_back (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              q_valid,
  output logic             q_pop,
  input  ppt_pkg::cmd_t    q_cmd,
  output logic             out_tvalid,
  input  wire              out_tready,
  output logic [63:0]      out_tdata,
  output logic [1:0]       out_tuser
);
  import ppt_pkg::*;
  `include "pairwise_preference_tally_assert.svh"

  localparam logic [3:0] S_IDLE = 4'd0, S_ERD = 4'd1, S_ECHK = 4'd2, S_EWB = 4'd3,
    S_BSET = 4'd4, S_BRD = 4'd5, S_BCHK = 4'd6, S_BWB = 4'd7, S_RRD = 4'd8,
    S_RWT = 4'd9, S_CLR = 4'd10, S_DONE = 4'd11, S_ERDW = 4'd12, S_BRDW = 4'd13;

  logic [3:0] st_r;
  cmd_t cmd_r;
  logic [CntW-1:0] mem [MaxCand*MaxCand];
  logic [CntW-1:0] rdata_r;
  logic [AddrW-1:0] raddr, waddr_r;
  logic [CntW-1:0] wdata_r;
  logic we_r;
  logic [CandW-1:0] bcand [MaxLen];
  logic [31:0] bscore [MaxLen];
  logic [MaxCand-1:0] seen_r;
  logic [LenW:0] ecnt_r;
  logic [LenW:0] i_r;
  logic [CandW:0] bi_r, bj_r;
  logic [AddrW:0] clr_r;
  logic boot_r;
  logic [1:0] stat_r;
  logic sat_r;
  logic [CntW-1:0] cell_r, vsum_r;
  logic ovalid_r;
  logic [CntW:0] sum;
  logic [CandW-1:0] e_c;
  logic [31:0] e_s;

  assign e_c = bcand[i_r[LenW-1:0]];
  assign e_s = bscore[i_r[LenW-1:0]];
  assign sum = {1'b0, rdata_r} + (CntW+1)'(cmd_r.weight);

  always_comb begin
    case (st_r)
      S_ERD, S_ERDW: raddr = {e_c, cmd_r.cand};
      S_BRD, S_BRDW: raddr = {bi_r[CandW-1:0], bj_r[CandW-1:0]};
      default: raddr = {cmd_r.row, cmd_r.col};
    endcase
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (we_r) mem[waddr_r] <= wdata_r;
  end

  assign q_pop = (st_r == S_IDLE) && q_valid && !ovalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      clr_r <= '0;
      boot_r <= 1'b1;
      seen_r <= '0;
      ecnt_r <= '0;
      vsum_r <= '0;
      ovalid_r <= 1'b0;
      we_r <= 1'b0;
    end else begin
      we_r <= 1'b0;
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (q_pop) begin
            cmd_r <= q_cmd;
            i_r <= '0;
            stat_r <= ST_OK;
            sat_r <= 1'b0;
            cell_r <= '0;
            case (q_cmd.req)
              REQ_ENTRY: begin
                if ({1'b0, q_cmd.cand} >= q_cmd.n) begin
                  stat_r <= ST_RANGE;
                  st_r <= q_cmd.ends ? S_BSET : S_DONE;
                end else if (32'(ecnt_r) >= MaxLen) begin
                  stat_r <= ST_LONG;
                  st_r <= q_cmd.ends ? S_BSET : S_DONE;
                end else st_r <= S_ERD;
              end
              REQ_READ: begin
                if ({1'b0, q_cmd.row} >= q_cmd.n || {1'b0, q_cmd.col} >= q_cmd.n) begin
                  stat_r <= ST_RANGE;
                  st_r <= S_DONE;
                end else st_r <= S_RRD;
              end
              REQ_CLEAR: begin
                clr_r <= '0;
                vsum_r <= '0;
                st_r <= S_CLR;
              end
              default: st_r <= S_DONE;
            endcase
          end
        end
        S_ERD: begin
          if (i_r == ecnt_r) begin
            bcand[ecnt_r[LenW-1:0]] <= cmd_r.cand;
            bscore[ecnt_r[LenW-1:0]] <= cmd_r.score;
            ecnt_r <= ecnt_r + 1'b1;
            seen_r[cmd_r.cand] <= 1'b1;
            st_r <= cmd_r.ends ? S_BSET : S_DONE;
          end else if ({1'b0, e_c} >= cmd_r.n || e_s == cmd_r.score) begin
            i_r <= i_r + 1'b1;
          end else begin
            waddr_r <= {e_c, cmd_r.cand};
            st_r <= S_ERDW;
          end
        end
        S_ERDW: st_r <= S_ECHK;
        S_ECHK: begin
          we_r <= 1'b1;
          if (sum[CntW]) begin
            wdata_r <= CntMax;
            sat_r <= 1'b1;
          end else wdata_r <= sum[CntW-1:0];
          st_r <= S_EWB;
        end
        S_EWB: begin
          i_r <= i_r + 1'b1;
          st_r <= S_ERD;
        end
        S_BSET: begin
          if ({1'b0, vsum_r} + (CntW+1)'(cmd_r.weight) > (CntW+1)'(CntMax)) begin
            vsum_r <= CntMax;
            sat_r <= 1'b1;
          end else vsum_r <= vsum_r + CntW'(cmd_r.weight);
          bi_r <= '0;
          bj_r <= '0;
          st_r <= S_BRD;
        end
        S_BRD: begin
          if (bi_r == cmd_r.n) begin
            seen_r <= '0;
            ecnt_r <= '0;
            st_r <= S_DONE;
          end else if (bj_r == cmd_r.n) begin
            bj_r <= '0;
            bi_r <= bi_r + 1'b1;
          end else if (!seen_r[bi_r[CandW-1:0]] || seen_r[bj_r[CandW-1:0]]) begin
            bj_r <= bj_r + 1'b1;
          end else begin
            waddr_r <= {bi_r[CandW-1:0], bj_r[CandW-1:0]};
            st_r <= S_BRDW;
          end
        end
        S_BRDW: st_r <= S_BCHK;
        S_BCHK: begin
          we_r <= 1'b1;
          if (sum[CntW]) begin
            wdata_r <= CntMax;
            sat_r <= 1'b1;
          end else wdata_r <= sum[CntW-1:0];
          st_r <= S_BWB;
        end
        S_BWB: begin
          bj_r <= bj_r + 1'b1;
          st_r <= S_BRD;
        end
        S_RRD: st_r <= S_RWT;
        S_RWT: begin
          cell_r <= rdata_r;
          st_r <= S_DONE;
        end
        S_CLR: begin
          we_r <= 1'b1;
          waddr_r <= clr_r[AddrW-1:0];
          wdata_r <= '0;
          clr_r <= clr_r + 1'b1;
          if (clr_r == (AddrW+1)'(MaxCand*MaxCand-1)) begin
            st_r <= boot_r ? S_IDLE : S_DONE;
            boot_r <= 1'b0;
          end
        end
        S_DONE: begin
          if (!ovalid_r || out_tready) begin
            ovalid_r <= 1'b1;
            out_tdata <= {vsum_r, cell_r};
            out_tuser <= (stat_r == ST_OK && sat_r) ? ST_SAT : stat_r;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;

  `PPT_ASSERT_IMP(a_pop_idle, clk, rst_n, q_pop, st_r == S_IDLE)
  `PPT_ASSERT_IMP(a_len, clk, rst_n, 1'b1, 32'(ecnt_r) <= MaxLen)
  `PPT_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
endmodule
`default_nettype wire

@@ rtl/pairwise_preference_tally.sv @@
// ----------------------------------------------------------------------------
// pairwise_preference_tally
// weighted pairwise preference matrix from ranked ballot beats
// ----------------------------------------------------------------------------
// entry: each earlier buffered entry that updates a cell goes through read, wait, check and writeback states
// ballot end: walks every candidate pair and row, with read, wait, check and writeback per ranked/unranked update
// one beat per command, one command in flight
// after reset a clear pass zeroes all 256 matrix cells before any command executes
`default_nettype none
module pairwise_preference_tally (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [4:0]  cfg_wdata,
  input  wire         in_tvalid,
  output logic        in_tready,
  // cand_index, cand_score, ballot_weight, read_row, read_col
  input  wire  [63:0] in_tdata,
  // req_type
  input  wire  [1:0]  in_tuser,
  input  wire         in_tlast,
  output logic        out_tvalid,
  input  wire         out_tready,
  // cell_value, voter_total
  output logic [63:0] out_tdata,
  // status
  output logic [1:0]  out_tuser
);
  import ppt_pkg::*;

  cmd_t q_cmd;
  logic q_valid, q_pop;

  ppt_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_tvalid, .in_tready, .in_tdata,
    .in_tuser, .in_tlast, .q_valid, .q_pop, .q_cmd
  );

  ppt_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd, .out_tvalid, .out_tready,
    .out_tdata, .out_tuser
  );
endmodule
`default_nettype wire
